### hdl/adcv_pkg.sv
// Shared widths, constants and helper functions for the ADC lowpass block.
`timescale 1ns / 1ps
`default_nettype none

package adcv_pkg;

    // Field and register widths
    localparam int CODE_W   = 12;   // raw ADC code on the input item
    localparam int ALPHA_W  = 16;   // Q0.16 filter weight
    localparam int RATIO_W  = 16;   // Q4.12 divider ratio
    localparam int MODE_W   = 2;    // resolution select
    localparam int VOLT_W   = 24;   // Q8.16 volts
    localparam int TEMP_W   = 24;   // signed Q15.8 degrees

    // Scaler datapath widths
    localparam int MCAND_W  = CODE_W + 9;           // code * 264
    localparam int PROD_W   = MCAND_W + RATIO_W;    // code * ratio * 264
    localparam int DVD_W    = PROD_W + 1;           // 2 * num + den
    localparam int DEN_W    = 15;                   // 5 * full scale
    localparam int DIV_W    = DEN_W + 1;            // 2 * den
    localparam int X_W      = 28;                   // scaled sample, Q8.16 unsaturated
    localparam int STEP_W   = 5;                    // iteration counter

    // Filter datapath widths
    localparam int DIFF_W   = X_W + 1;              // prior - x, signed
    localparam int PSUM_W   = DIFF_W + ALPHA_W;     // alpha * diff, signed
    localparam int ACC_W    = PSUM_W + 1;           // full filter sum

    // Temperature: 329 C in Q15.8 is 84224; t = 84224 - (25*y + 8) / 16
    localparam int TWIDE_W  = TEMP_W + 2;
    localparam logic [TWIDE_W-1:0] TEMP_OFFSET = TWIDE_W'(84224);
    localparam logic [VOLT_W-1:0]  VOLT_MAX    = '1;

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RESOLUTION = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RATIO      = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_MODE  = 2'd3;
    localparam int CFG_DATA_W = 16;

    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(4096);

    // Resolution codes
    localparam logic [MODE_W-1:0] RES_12BIT = 2'd0;
    localparam logic [MODE_W-1:0] RES_10BIT = 2'd1;
    localparam logic [MODE_W-1:0] RES_8BIT  = 2'd2;
    localparam logic [MODE_W-1:0] RES_6BIT  = 2'd3;

    // Five times the full-scale code of each resolution
    function automatic logic [DEN_W-1:0] den_of(input logic [MODE_W-1:0] mode);
        logic [DEN_W-1:0] d;
        unique case (mode)
            RES_12BIT: d = DEN_W'(5 * 4095);
            RES_10BIT: d = DEN_W'(5 * 1023);
            RES_8BIT:  d = DEN_W'(5 * 255);
            RES_6BIT:  d = DEN_W'(5 * 63);
            default:   d = DEN_W'(5 * 4095);
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### hdl/adc_lowpass_volt_temp.sv
// Top level: ADC code to filtered volts and sensor temperature, stream ports.
`timescale 1ns / 1ps
`default_nettype none

// Each input item carries one raw ADC code. The block scales it to volts as
// code * 3.3 V * divider_ratio / full scale (4095, 1023, 255 or 63 by the
// resolution register), runs the lowpass y = a*y_prev + (1-a)*x and returns
// one result item per input item: the filtered Q8.16 voltage, and, when
// temperature mode is on, the sensor temperature 329 - 400*y in signed Q15.8
// with tuser high. One item is worked on at a time. The scaler runs the
// bit-serial ratio multiply and then the restoring divide, and the filter
// runs the bit-serial alpha multiply. The next item is accepted as soon as
// the result has moved to the output register, even while that result
// still waits for m_tready. Configuration writes are taken at any edge
// with cfg_we high, but are meant to happen only while no item is in
// flight. Only the low SAMPLE_BITS bits of the code, at most 12, are used.
module adc_lowpass_volt_temp
    import adcv_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // input item
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [11:0] sample_code, rest zero

    // result item
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [47:0]                m_tdata,   // [23:0] filtered_volts, [47:24] temperature
    output logic                       m_tuser,   // [0] temperature_valid

    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [REG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        TP_IDLE  = 4'b0001,
        TP_SCALE = 4'b0010,
        TP_FILT  = 4'b0100,
        TP_OUT   = 4'b1000
    } tp_state_t;

    localparam int USED_W = (SAMPLE_BITS < CODE_W) ? SAMPLE_BITS : CODE_W;
    localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'((64'd1 << USED_W) - 64'd1);

    // configuration
    logic [ALPHA_W-1:0]   alpha_reg;
    logic [MODE_W-1:0]    res_mode_reg;
    logic [RATIO_W-1:0]   ratio_reg;
    logic                 temp_mode_reg;

    // control and filter state
    tp_state_t            state_reg, state_next;
    logic [VOLT_W-1:0]    prior_reg, prior_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [VOLT_W-1:0]    out_volts_reg, out_volts_next;
    logic [TEMP_W-1:0]    out_temp_reg, out_temp_next;
    logic                 out_tvld_reg, out_tvld_next;

    logic                 in_fire;
    logic                 out_free;
    logic [CODE_W-1:0]    code;
    logic                 scale_done;
    logic [X_W-1:0]       scale_x;
    logic                 ema_done;
    logic [VOLT_W-1:0]    ema_y;

    // temperature from the stored voltage
    logic [VOLT_W+4:0]    y25;
    logic [TWIDE_W-1:0]   temp_wide;
    logic [TEMP_W-1:0]    temp_sat;

    assign s_tready = (state_reg == TP_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign code     = s_tdata[CODE_W-1:0] & CODE_MASK;

    adcv_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_fire),
        .code  (code),
        .ratio (ratio_reg),
        .den   (den_of(res_mode_reg)),
        .done  (scale_done),
        .x     (scale_x)
    );

    adcv_ema u_ema (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_done),
        .x     (scale_x),
        .prior (prior_reg),
        .alpha (alpha_reg),
        .done  (ema_done),
        .y     (ema_y)
    );

    // 25*y + 8, then divide by 16 and take it from 329 degrees
    always_comb
    begin
        y25       = (29'(prior_reg) << 4) + (29'(prior_reg) << 3) + 29'(prior_reg) + 29'd8;
        temp_wide = TEMP_OFFSET - TWIDE_W'(y25[VOLT_W+4:4]);
        if ($signed(temp_wide) < -$signed(TWIDE_W'(1) << (TEMP_W - 1)))
        begin
            temp_sat = {1'b1, {(TEMP_W-1){1'b0}}};
        end
        else if ($signed(temp_wide) > $signed((TWIDE_W'(1) << (TEMP_W - 1)) - 1'b1))
        begin
            temp_sat = {1'b0, {(TEMP_W-1){1'b1}}};
        end
        else
        begin
            temp_sat = temp_wide[TEMP_W-1:0];
        end
    end

    // sequence one item through scaler, filter and output register
    always_comb
    begin
        state_next     = state_reg;
        prior_next     = prior_reg;
        out_valid_next = out_valid_reg;
        out_volts_next = out_volts_reg;
        out_temp_next  = out_temp_reg;
        out_tvld_next  = out_tvld_reg;

        // drop the result once the sink takes it
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            TP_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = TP_SCALE;
                end
            end
            TP_SCALE:
            begin
                if (scale_done)
                begin
                    state_next = TP_FILT;
                end
            end
            TP_FILT:
            begin
                // the saturated voltage becomes the new filter state
                if (ema_done)
                begin
                    prior_next = ema_y;
                    state_next = TP_OUT;
                end
            end
            TP_OUT:
            begin
                // hold until the output register is free, then hand over
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_volts_next = prior_reg;
                    out_temp_next  = temp_mode_reg ? temp_sat : '0;
                    out_tvld_next  = temp_mode_reg;
                    state_next     = TP_IDLE;
                end
            end
            default:
            begin
                state_next = TP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TP_IDLE;
            prior_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prior_reg     <= prior_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_volts_reg <= out_volts_next;
        out_temp_reg  <= out_temp_next;
        out_tvld_reg  <= out_tvld_next;
    end

    // register writes; each keeps only its own width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= '0;
            res_mode_reg  <= RES_12BIT;
            ratio_reg     <= RATIO_RESET;
            temp_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ALPHA:      alpha_reg     <= cfg_wdata[ALPHA_W-1:0];
                REG_RESOLUTION: res_mode_reg  <= cfg_wdata[MODE_W-1:0];
                REG_RATIO:      ratio_reg     <= cfg_wdata[RATIO_W-1:0];
                REG_TEMP_MODE:  temp_mode_reg <= cfg_wdata[0];
                default:        temp_mode_reg <= temp_mode_reg;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_temp_reg, out_volts_reg};
    assign m_tuser  = out_tvld_reg;

endmodule

`default_nettype wire

### hdl/adcv_scale.sv
// Bit-serial code-to-volts scaler: shift-add multiply, then restoring divide.
`timescale 1ns / 1ps
`default_nettype none

module adcv_scale
    import adcv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [CODE_W-1:0]  code,
    input  wire logic [RATIO_W-1:0] ratio,
    input  wire logic [DEN_W-1:0]   den,
    output logic                    done,
    output logic [X_W-1:0]          x
);

    typedef enum logic [3:0] {
        SC_IDLE = 4'b0001,
        SC_MUL  = 4'b0010,
        SC_LOAD = 4'b0100,
        SC_DIV  = 4'b1000
    } sc_state_t;

    sc_state_t            state_reg, state_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [MCAND_W-1:0]   mcand_reg, mcand_next;
    logic [RATIO_W-1:0]   mplier_reg, mplier_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [X_W-1:0]       quo_reg, quo_next;

    logic [DVD_W-1:0]     dvd;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       divisor;
    logic                 fits;

    assign dvd     = {prod_reg, 1'b0} + DVD_W'(den_reg);
    assign divisor = {1'b0, den_reg, 1'b0};
    assign trial   = {rem_reg, quo_reg[X_W-1]};
    assign fits    = (trial >= divisor);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        unique case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    // code * 264 = code * 256 + code * 8
                    mcand_next  = (MCAND_W'(code) << 8) + (MCAND_W'(code) << 3);
                    mplier_next = ratio;
                    prod_next   = '0;
                    den_next    = den;
                    cnt_next    = '0;
                    state_next  = SC_MUL;
                end
            end
            SC_MUL:
            begin
                // one ratio bit per cycle, most significant first
                prod_next   = {prod_reg[PROD_W-2:0], 1'b0}
                              + (mplier_reg[RATIO_W-1] ? PROD_W'(mcand_reg) : '0);
                mplier_next = {mplier_reg[RATIO_W-2:0], 1'b0};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(RATIO_W - 1))
                begin
                    state_next = SC_LOAD;
                end
            end
            SC_LOAD:
            begin
                // quotient fits in X_W bits, so the top bits start as remainder
                rem_next   = DIV_W'(dvd[DVD_W-1:X_W]);
                quo_next   = dvd[X_W-1:0];
                cnt_next   = '0;
                state_next = SC_DIV;
            end
            SC_DIV:
            begin
                rem_next = fits ? DIV_W'(trial - divisor) : trial[DIV_W-1:0];
                quo_next = {quo_reg[X_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(X_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = SC_IDLE;
                end
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
    end

    assign done = done_reg;
    assign x    = quo_reg;

endmodule

`default_nettype wire

### hdl/adcv_ema.sv
// Bit-serial first-order lowpass update: y = x + alpha * (prior - x) / 2^16.
`timescale 1ns / 1ps
`default_nettype none

module adcv_ema
    import adcv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [X_W-1:0]     x,
    input  wire logic [VOLT_W-1:0]  prior,
    input  wire logic [ALPHA_W-1:0] alpha,
    output logic                    done,
    output logic [VOLT_W-1:0]       y
);

    typedef enum logic [2:0] {
        EM_IDLE = 3'b001,
        EM_MUL  = 3'b010,
        EM_SUM  = 3'b100
    } em_state_t;

    em_state_t                 state_reg, state_next;
    logic [STEP_W-1:0]         cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic [X_W-1:0]            x_reg, x_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic [ALPHA_W-1:0]        alpha_reg, alpha_next;
    logic signed [PSUM_W-1:0]  psum_reg, psum_next;
    logic [VOLT_W-1:0]         y_reg, y_next;

    logic signed [ACC_W-1:0]   acc;

    // 65536*x + alpha*(prior - x) + rounding half; never negative
    assign acc = $signed({1'b0, x_reg, {ALPHA_W{1'b0}}})
                 + ACC_W'(psum_reg)
                 + $signed(ACC_W'(32768));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        diff_next  = diff_reg;
        alpha_next = alpha_reg;
        psum_next  = psum_reg;
        y_next     = y_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (start)
                begin
                    x_next     = x;
                    diff_next  = $signed(DIFF_W'(prior)) - $signed(DIFF_W'(x));
                    alpha_next = alpha;
                    psum_next  = '0;
                    cnt_next   = '0;
                    state_next = EM_MUL;
                end
            end
            EM_MUL:
            begin
                // one alpha bit per cycle, most significant first
                psum_next  = (psum_reg <<< 1)
                             + (alpha_reg[ALPHA_W-1] ? PSUM_W'(diff_reg) : '0);
                alpha_next = {alpha_reg[ALPHA_W-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(ALPHA_W - 1))
                begin
                    state_next = EM_SUM;
                end
            end
            EM_SUM:
            begin
                // saturate when anything lands above the Q8.16 range
                y_next     = (|acc[ACC_W-1:VOLT_W+ALPHA_W]) ? VOLT_MAX
                                                            : acc[VOLT_W+ALPHA_W-1:ALPHA_W];
                done_next  = 1'b1;
                state_next = EM_IDLE;
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        diff_reg  <= diff_next;
        alpha_reg <= alpha_next;
        psum_reg  <= psum_next;
        y_reg     <= y_next;
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

`default_nettype wire

### hdl/adcv_checker.sv
// Port-level assertions for the ADC lowpass block and their bind.
`timescale 1ns / 1ps
`default_nettype none

module adcv_checker
    import adcv_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item at a time: an accepted item closes the input
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open right after an accept");

    // with temperature off the temperature field reads zero
    a_temp_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[47:24] == 24'd0)
        else $error("temperature field set with temperature off");

    // temperature never exceeds 329 degrees, the zero-volt point
    a_temp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> $signed(m_tdata[47:24]) <= $signed(24'd84224))
        else $error("temperature above the zero-volt point");

endmodule

bind adc_lowpass_volt_temp adcv_checker u_adcv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
